@@ sv/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// psd_pkg
// Types, coefficient tables and angle constants for the phase-shift decoder.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int PHASE_BITS     = 16;
  localparam int MAX_PHASES     = 8;
  localparam int MIN_PHASES     = 3;
  localparam int COUNT_BITS     = 4;
  localparam int ROW_COUNT      = 6;
  localparam int ROW_BITS       = 3;
  localparam int COEF_BITS      = 17;
  localparam int PROD_BITS      = SAMPLE_BITS + 1 + COEF_BITS;
  localparam int PAIR_BITS      = PROD_BITS + 1;
  localparam int SUM_BITS       = PROD_BITS + 3;
  localparam int PRESCALE_SHIFT = 16;
  localparam int CORDIC_BITS    = SUM_BITS + PRESCALE_SHIFT + 1;
  localparam int CORDIC_STEPS   = 28;
  localparam int ANGLE_BITS     = 32;

  localparam logic [COUNT_BITS-1:0] PHASE_COUNT_RESET = COUNT_BITS'(4);
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
    logic [SAMPLE_BITS-1:0] sample_5;
    logic [SAMPLE_BITS-1:0] sample_6;
    logic [SAMPLE_BITS-1:0] sample_7;
  } sample_set_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase_fraction;
    logic                  zero_amplitude;
  } result_t;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  // one row per step count, N = 3 .. 8; columns past N are zero
  localparam coef_t COS_TAB [ROW_COUNT][MAX_PHASES] = '{
    '{17'sd32768, -17'sd16384, -17'sd16384, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
    '{17'sd32768, 17'sd0, -17'sd32768, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
    '{17'sd32768, 17'sd10126, -17'sd26510, -17'sd26510, 17'sd10126, 17'sd0, 17'sd0,
      17'sd0},
    '{17'sd32768, 17'sd16384, -17'sd16384, -17'sd32768, -17'sd16384, 17'sd16384,
      17'sd0, 17'sd0},
    '{17'sd32768, 17'sd20431, -17'sd7292, -17'sd29523, -17'sd29523, -17'sd7292,
      17'sd20431, 17'sd0},
    '{17'sd32768, 17'sd23170, 17'sd0, -17'sd23170, -17'sd32768, -17'sd23170, 17'sd0,
      17'sd23170}
  };

  localparam coef_t SIN_TAB [ROW_COUNT][MAX_PHASES] = '{
    '{17'sd0, 17'sd28378, -17'sd28378, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
    '{17'sd0, 17'sd32768, 17'sd0, -17'sd32768, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
    '{17'sd0, 17'sd31164, 17'sd19261, -17'sd19261, -17'sd31164, 17'sd0, 17'sd0, 17'sd0},
    '{17'sd0, 17'sd28378, 17'sd28378, 17'sd0, -17'sd28378, -17'sd28378, 17'sd0, 17'sd0},
    '{17'sd0, 17'sd25619, 17'sd31946, 17'sd14218, -17'sd14218, -17'sd31946,
      -17'sd25619, 17'sd0},
    '{17'sd0, 17'sd23170, 17'sd32768, 17'sd23170, 17'sd0, -17'sd23170, -17'sd32768,
      -17'sd23170}
  };

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32
  localparam logic [ANGLE_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
  };

endpackage

@@ sv/phase_shift_decoder.sv @@
// Fully pipelined decoder: one pixel may be started in every clock cycle and
// busy never rises. Each started pixel returns one result on result, marked by
// done for a single cycle. The pipeline is, in order: input register,
// coefficient multiply, two adder-tree stages, CORDIC set-up, one stage per
// each of the 28 CORDIC micro-rotations, and the rounding register. Results
// must be taken when done is high; there is no hold-off.
// phase_count may be written whenever no pixel is in flight.
// ----------------------------------------------------------------------------
// phase_shift_decoder
// Per-pixel N-step phase-shift decoder returning the wrapped phase as a
// fraction of one turn, with a flag for pixels without fringe modulation.
// ----------------------------------------------------------------------------
module phase_shift_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  psd_pkg::sample_set_t               samples,
  output logic                               done,
  output psd_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [psd_pkg::COUNT_BITS-1:0]     cfg_data
);
  import psd_pkg::*;

  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [PAIR_BITS-1:0]   pair_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic signed [CORDIC_BITS-1:0] vec_t;

  localparam logic [ANGLE_BITS-1:0] ROUND_INC =
    ANGLE_BITS'(1) << (ANGLE_BITS - 1 - PHASE_BITS);

  // configuration register
  logic [COUNT_BITS-1:0] phase_count;
  logic [COUNT_BITS-1:0] count_clamped;
  logic [ROW_BITS-1:0]   row_next;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= PHASE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phase_count <= cfg_data;
    end
  end

  always_comb begin
    if (phase_count < COUNT_BITS'(MIN_PHASES)) begin
      count_clamped = COUNT_BITS'(MIN_PHASES);
    end else if (phase_count > COUNT_BITS'(MAX_PHASES)) begin
      count_clamped = COUNT_BITS'(MAX_PHASES);
    end else begin
      count_clamped = phase_count;
    end
    row_next = ROW_BITS'(count_clamped - COUNT_BITS'(MIN_PHASES));
  end

  // stage a: input capture
  logic                   a_valid;
  sample_set_t            a_samp;
  logic [ROW_BITS-1:0]    a_row;
  logic [SAMPLE_BITS-1:0] a_arr [MAX_PHASES];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_samp <= samples;
    a_row  <= row_next;
  end

  assign a_arr[0] = a_samp.sample_0;
  assign a_arr[1] = a_samp.sample_1;
  assign a_arr[2] = a_samp.sample_2;
  assign a_arr[3] = a_samp.sample_3;
  assign a_arr[4] = a_samp.sample_4;
  assign a_arr[5] = a_samp.sample_5;
  assign a_arr[6] = a_samp.sample_6;
  assign a_arr[7] = a_samp.sample_7;

  // stage b: coefficient products, zero past N by construction of the tables
  logic  b_valid;
  prod_t b_cos [MAX_PHASES];
  prod_t b_sin [MAX_PHASES];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < MAX_PHASES; r++) begin
      b_cos[r] <= prod_t'($signed({1'b0, a_arr[r]})) * prod_t'(COS_TAB[a_row][r]);
      b_sin[r] <= prod_t'($signed({1'b0, a_arr[r]})) * prod_t'(SIN_TAB[a_row][r]);
    end
  end

  // stage c: pairwise sums
  localparam int PAIRS = MAX_PHASES / 2;
  logic  c_valid;
  pair_t c_cos [PAIRS];
  pair_t c_sin [PAIRS];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < PAIRS; p++) begin
      c_cos[p] <= pair_t'(b_cos[2*p]) + pair_t'(b_cos[2*p+1]);
      c_sin[p] <= pair_t'(b_sin[2*p]) + pair_t'(b_sin[2*p+1]);
    end
  end

  // stage d: full projections C and S
  logic d_valid;
  sum_t d_c;
  sum_t d_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_c <= (sum_t'(c_cos[0]) + sum_t'(c_cos[1])) + (sum_t'(c_cos[2]) + sum_t'(c_cos[3]));
    d_s <= (sum_t'(c_sin[0]) + sum_t'(c_sin[1])) + (sum_t'(c_sin[2]) + sum_t'(c_sin[3]));
  end

  // cordic pipeline: index 0 is the set-up stage, index k+1 follows rotation k
  logic                  cv [CORDIC_STEPS+1];
  logic                  czero [CORDIC_STEPS+1];
  vec_t                  cx [CORDIC_STEPS+1];
  vec_t                  cy [CORDIC_STEPS+1];
  logic [ANGLE_BITS-1:0] cz [CORDIC_STEPS+1];
  vec_t                  x_wide;
  vec_t                  y_wide;

  // scale both projections by 2^16 ahead of the rotations, keeping the sign
  assign x_wide = vec_t'($signed({d_s, {PRESCALE_SHIFT{1'b0}}}));
  assign y_wide = vec_t'($signed({d_c, {PRESCALE_SHIFT{1'b0}}}));

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    czero[0] <= (d_c == '0) && (d_s == '0);
    // left half-plane: turn by half a turn first
    if (d_s < 0) begin
      cx[0] <= -x_wide;
      cy[0] <= -y_wide;
      cz[0] <= HALF_TURN;
    end else begin
      cx[0] <= x_wide;
      cy[0] <= y_wide;
      cz[0] <= '0;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else begin
        cv[k+1] <= cv[k];
      end
    end

    always_ff @(posedge clk) begin
      czero[k+1] <= czero[k];
      if (cy[k] < 0) begin
        cx[k+1] <= cx[k] - (cy[k] >>> k);
        cy[k+1] <= cy[k] + (cx[k] >>> k);
        cz[k+1] <= cz[k] - ATAN_TAB[k];
      end else begin
        cx[k+1] <= cx[k] + (cy[k] >>> k);
        cy[k+1] <= cy[k] - (cx[k] >>> k);
        cz[k+1] <= cz[k] + ATAN_TAB[k];
      end
    end
  end

  // output register: round to PHASE_BITS, a full turn wraps to zero
  logic [ANGLE_BITS-1:0] z_rounded;
  assign z_rounded = cz[CORDIC_STEPS] + ROUND_INC;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    result.zero_amplitude <= czero[CORDIC_STEPS];
    if (czero[CORDIC_STEPS]) begin
      result.phase_fraction <= '0;
    end else begin
      result.phase_fraction <= z_rounded[ANGLE_BITS-1 -: PHASE_BITS];
    end
  end

  // fixed latency from start to done
  localparam int LATENCY = CORDIC_STEPS + 6;

  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("started transaction did not complete on time");

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a started transaction");

  assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_amplitude) |-> (result.phase_fraction == '0))
    else $error("zero-amplitude result carries a nonzero phase");

endmodule

@@ dv/phase_shift_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_shift_decoder_test
// Self-checking bench for the N-step phase-shift decoder. A directed table of
// pixels (flat pixels, single-lane pixels, clamped step counts) is followed
// by bursts of random pixels under several step counts. Typed rows are checked
// against the table, the rest against a bit-exact integer CORDIC model in the bench.
// ----------------------------------------------------------------------------
module phase_shift_decoder_test;
  import psd_pkg::*;

  localparam int LATENCY        = 34;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PIXELS_PER_SET = 65;

  typedef struct {
    logic [COUNT_BITS-1:0] count;
    sample_set_t           px;
    bit                    typed;
    result_t               want;
  } pixel_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  sample_set_t           samples;
  logic                  done;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [COUNT_BITS-1:0] cfg_data;

  // Q2.15 projection weights, one row of eight per step count 3 .. 8
  int cos_q15 [48] = '{
    32768, -16384, -16384, 0, 0, 0, 0, 0,
    32768, 0, -32768, 0, 0, 0, 0, 0,
    32768, 10126, -26510, -26510, 10126, 0, 0, 0,
    32768, 16384, -16384, -32768, -16384, 16384, 0, 0,
    32768, 20431, -7292, -29523, -29523, -7292, 20431, 0,
    32768, 23170, 0, -23170, -32768, -23170, 0, 23170
  };
  int sin_q15 [48] = '{
    0, 28378, -28378, 0, 0, 0, 0, 0,
    0, 32768, 0, -32768, 0, 0, 0, 0,
    0, 31164, 19261, -19261, -31164, 0, 0, 0,
    0, 28378, 28378, 0, -28378, -28378, 0, 0,
    0, 25619, 31946, 14218, -14218, -31946, -25619, 0,
    0, 23170, 32768, 23170, 0, -23170, -32768, -23170
  };
  // atan(2^-i) in turns, scaled by 2^32
  logic [31:0] atan_turn [28] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  logic [COUNT_BITS-1:0] step_count;
  result_t               decoded_due [$];
  pixel_row_t            directed_rows [$];
  int                    pixels_sent;
  int                    results_seen;
  int                    flat_seen;
  int                    count_writes;
  int                    bad_count;
  int                    quiet_cycles;

  phase_shift_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .samples   (samples),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t decode_pixel(input sample_set_t px,
                                           input logic [COUNT_BITS-1:0] cnt);
    logic [MAX_PHASES*SAMPLE_BITS-1:0] lanes;
    longint signed c_sum, s_sum, x, y, dx, dy;
    logic [31:0] z, rounded;
    int n, r, i;
    result_t res;
    lanes = px;
    n = cnt;
    if (n < MIN_PHASES) n = MIN_PHASES;
    if (n > MAX_PHASES) n = MAX_PHASES;
    c_sum = 0;
    s_sum = 0;
    for (r = 0; r < n; r++) begin
      c_sum += longint'(lanes[(MAX_PHASES-1-r)*SAMPLE_BITS +: SAMPLE_BITS])
               * cos_q15[(n-MIN_PHASES)*MAX_PHASES + r];
      s_sum += longint'(lanes[(MAX_PHASES-1-r)*SAMPLE_BITS +: SAMPLE_BITS])
               * sin_q15[(n-MIN_PHASES)*MAX_PHASES + r];
    end
    if (c_sum == 0 && s_sum == 0) begin
      res.phase_fraction = '0;
      res.zero_amplitude = 1'b1;
      return res;
    end
    // vectoring CORDIC with y = C, x = S
    y = c_sum * 65536;
    x = s_sum * 65536;
    z = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_turn[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_turn[i];
      end
    end
    rounded = z + 32'h00008000;
    res.phase_fraction = rounded[31:16];
    res.zero_amplitude = 1'b0;
    return res;
  endfunction

  function automatic sample_set_t random_pixel();
    logic [SAMPLE_BITS-1:0] lane [MAX_PHASES];
    int kind, base, r;
    kind = $urandom_range(0, 9);
    base = $urandom_range(4, 4091);
    for (r = 0; r < MAX_PHASES; r++) begin
      case (kind)
        5: lane[r] = SAMPLE_BITS'(base);  // no fringe modulation at all
        6: lane[r] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        7: lane[r] = SAMPLE_BITS'(base + int'($urandom_range(0, 6)) - 3);  // faint modulation
        default: lane[r] = SAMPLE_BITS'($urandom_range(0, 4095));
      endcase
    end
    return {lane[0], lane[1], lane[2], lane[3], lane[4], lane[5], lane[6], lane[7]};
  endfunction

  task automatic add_row(input logic [COUNT_BITS-1:0] cnt, input sample_set_t px,
                         input bit typed, input logic [PHASE_BITS-1:0] phase,
                         input logic flat);
    pixel_row_t row;
    row.count = cnt;
    row.px = px;
    row.typed = typed;
    row.want.phase_fraction = phase;
    row.want.zero_amplitude = flat;
    directed_rows.push_back(row);
  endtask

  task automatic send_pixel(input sample_set_t px, input bit typed, input result_t want);
    @(negedge clk);
    start <= 1'b1;
    samples <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    decoded_due.push_back(typed ? want : decode_pixel(px, step_count));
    pixels_sent++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (decoded_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_step_count(input logic [COUNT_BITS-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    step_count = value;
    count_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (decoded_due.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("result with nothing outstanding: phase %h flat %b",
                 got.phase_fraction, got.zero_amplitude);
    end else begin
      want = decoded_due.pop_front();
      results_seen++;
      if (got.zero_amplitude === 1'b1) flat_seen++;
      if (got.phase_fraction !== want.phase_fraction ||
          got.zero_amplitude !== want.zero_amplitude) begin
        bad_count++;
        if (bad_count <= 10)
          $display("result %0d: want phase %h flat %b, got phase %h flat %b",
                   results_seen, want.phase_fraction, want.zero_amplitude,
                   got.phase_fraction, got.zero_amplitude);
      end
    end
  endtask

  // result checking and a watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (done) check_result(result);
      if ((start && !busy) || done || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("phase_shift_decoder_test failed");
        $finish;
      end
    end
  end

  initial begin
    int p, k, burst, gap, pause_at;
    logic [COUNT_BITS-1:0] next_count;
    rst = 1'b1;
    start = 1'b0;
    samples = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    step_count = PHASE_COUNT_RESET;
    pixels_sent = 0;
    results_seen = 0;
    flat_seen = 0;
    count_writes = 0;
    bad_count = 0;
    quiet_cycles = 0;

    // reset value N = 4: C = s0 - s2, S = s1 - s3
    add_row(4, {8{12'h000}}, 1, 16'h0000, 1);
    add_row(4, {8{12'hFFF}}, 1, 16'h0000, 1);
    add_row(4, {12'hFFF, {7{12'h000}}}, 1, 16'h4000, 0);
    add_row(4, {12'h000, 12'hFFF, {6{12'h000}}}, 1, 16'h0000, 0);
    add_row(4, {{2{12'h000}}, 12'hFFF, {5{12'h000}}}, 1, 16'hC000, 0);
    add_row(4, {{3{12'h000}}, 12'hFFF, {4{12'h000}}}, 1, 16'h8000, 0);
    add_row(4, {{2{12'hFFF}}, {6{12'h000}}}, 1, 16'h2000, 0);
    add_row(4, {{4{12'h000}}, {4{12'hFFF}}}, 1, 16'h0000, 1);  // lanes past N ignored
    add_row(4, {12'h001, {7{12'h000}}}, 1, 16'h4000, 0);
    add_row(4, {{3{12'h000}}, 12'h001, {4{12'h000}}}, 1, 16'h8000, 0);
    add_row(4, {12'h123, 12'hABC, 12'h555, 12'hAAA, {4{12'h000}}}, 0, 16'h0, 0);
    add_row(3, {{3{12'h7D0}}, {5{12'hFFF}}}, 1, 16'h0000, 1);
    add_row(3, {12'hFFF, {7{12'h000}}}, 1, 16'h4000, 0);
    add_row(3, {12'd100, 12'd3000, 12'hFFF, {5{12'hA5A}}}, 0, 16'h0, 0);
    add_row(8, {8{12'hFFF}}, 1, 16'h0000, 1);
    add_row(8, {{2{12'h000}}, 12'hFFF, {5{12'h000}}}, 1, 16'h0000, 0);
    add_row(8, {4{12'hFFF, 12'h000}}, 0, 16'h0, 0);
    // step counts outside 3 .. 8 clamp to the nearest end
    add_row(0, {{3{12'h007}}, {5{12'h5A5}}}, 1, 16'h0000, 1);
    add_row(0, {12'hFFF, {7{12'h000}}}, 1, 16'h4000, 0);
    add_row(15, {{6{12'h000}}, 12'hFFF, 12'h000}, 1, 16'h8000, 0);
    add_row(15, {12'h8F1, 12'h0E7, 12'h3C3, 12'hC3C, 12'h001, 12'hFFE, 12'h7FF, 12'h800},
            0, 16'h0, 0);
    add_row(5, {12'h800, 12'h7FF, 12'hFFF, 12'h000, 12'h123, {3{12'h000}}}, 0, 16'h0, 0);
    add_row(6, {12'h0F0, 12'hF0F, 12'h333, 12'hCCC, 12'h999, 12'h666, {2{12'h000}}},
            0, 16'h0, 0);
    add_row(7, {12'hFFF, 12'h000, 12'h001, 12'hFFE, 12'h400, 12'hBFF, 12'h2AA, 12'h000},
            0, 16'h0, 0);
    add_row(4, {12'hDEA, 12'h0BE, 12'hEF1, 12'h234, {4{12'hFFF}}}, 0, 16'h0, 0);

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].count != step_count) write_step_count(directed_rows[k].count);
      send_pixel(directed_rows[k].px, directed_rows[k].typed, directed_rows[k].want);
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 3));
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: next_count = 4'd0;
        1: next_count = 4'd15;
        2: next_count = 4'd3;
        3: next_count = 4'd8;
        default: next_count = COUNT_BITS'($urandom_range(0, 15));
      endcase
      write_step_count(next_count);
      pause_at = (p == 4) ? $urandom_range(10, PIXELS_PER_SET - 10) : -1;
      k = 0;
      while (k < PIXELS_PER_SET) begin
        burst = $urandom_range(1, 24);
        while (burst > 0 && k < PIXELS_PER_SET) begin
          send_pixel(random_pixel(), 0, '0);
          if (k == pause_at) drain_results();  // hold off until the pipeline empties
          burst--;
          k++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        idle_cycles(gap);
      end
    end

    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    if (decoded_due.size() != 0) bad_count++;

    $display("decoded %0d pixels, %0d results checked, %0d step-count writes",
             pixels_sent, results_seen, count_writes);
    $display("%0d results flagged zero amplitude, %0d mismatches", flat_seen, bad_count);
    if (bad_count == 0) begin
      $display("phase_shift_decoder_test passed");
    end else begin
      $display("phase_shift_decoder_test failed");
    end
    $finish;
  end

endmodule
